@@ src/sprite_hex_text_parser_defines.svh @@
// assertion macros shared by the checker
`ifndef SPRITE_HEX_TEXT_PARSER_DEFINES_SVH
`define SPRITE_HEX_TEXT_PARSER_DEFINES_SVH

// checked only outside reset
`define SHP_ASSERT_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sprite parser check failed");

// checked on every edge, reset included
`define SHP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sprite parser check failed");

`endif

@@ src/shp_pkg.sv @@
package shp_pkg;

  // entries of the character queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_TRIM,
    PH_N1LEAD,
    PH_N1DIG,
    PH_N2LEAD,
    PH_N2DIG,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_DATA   = 1'b1
  } kind_t;

  // one classified character
  typedef struct packed {
    logic       start;
    logic       ws;
    logic       dec;
    logic       plus;
    logic       minus;
    logic       comma;
    logic       space;
    logic [3:0] lead_hit;
    logic [3:0] nib;
  } token_t;

endpackage

@@ src/sprite_hex_text_parser.sv @@
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_ch[7:0], in_start_req
// out       output     out_valid/out_stall out_kind, out_value[7:0],
//                                          out_frame_count[7:0], out_last
//
// one character per clock sustained while in_stall is low; an accepted character is
// written into the queue, then the parse step takes it into the result register
// the parse step handles one queued character per cycle, held back only while
// an unread result sits in the output register
// reset is synchronous on rst_n: clears queue, parser state and out_valid
// in_stall rises only when the character queue is full
module sprite_hex_text_parser #(
  parameter int Q_DEPTH = shp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_ch,
  input  logic       in_start_req,
  output logic       in_stall,
  output logic       out_valid,
  output logic       out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_frame_count,
  output logic       out_last,
  input  logic       out_stall
);
  import shp_pkg::*;

  // classified character stream between front and back
  logic   push, q_full, tok_valid, pop;
  token_t push_token, tok;

  // front: classify each character (whitespace, digit, sign, hex nibble,
  // match against each letter of the lead word) as it is accepted
  shp_front u_front (
    .in_valid     (in_valid),
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .push         (push),
    .push_token   (push_token)
  );

  // short queue so a stalled result does not stall the character source
  shp_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .full       (q_full),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .pop        (pop)
  );

  // back: parse state machine, header numbers, byte countdown and the
  // registered result transaction
  shp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .tok_valid       (tok_valid),
    .tok             (tok),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_frame_count (out_frame_count),
    .out_last        (out_last),
    .out_stall       (out_stall)
  );

endmodule

@@ src/shp_front.sv @@
module shp_front (
  input  logic            in_valid,
  input  logic [7:0]      in_ch,
  input  logic            in_start_req,
  output logic            in_stall,
  input  logic            q_full,
  output logic            push,
  output shp_pkg::token_t push_token
);
  import shp_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] LEAD_WORD [4] = '{8'h61, 8'h6E, 8'h69, 8'h6D};

  // hex digit value, anything else reads as zero
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_token.start = in_start_req;
    push_token.ws    = (in_ch == CH_SPACE) || (in_ch >= 8'h09 && in_ch <= 8'h0D);
    push_token.dec   = (in_ch >= 8'h30 && in_ch <= 8'h39);
    push_token.plus  = (in_ch == CH_PLUS);
    push_token.minus = (in_ch == CH_MINUS);
    push_token.comma = (in_ch == CH_COMMA);
    push_token.space = (in_ch == CH_SPACE);
    for (int i = 0; i < 4; i++) begin
      push_token.lead_hit[i] = (in_ch == LEAD_WORD[i]);
    end
    push_token.nib = hex_nib(in_ch);
  end

endmodule

@@ src/shp_fifo.sv @@
module shp_fifo #(
  parameter int DEPTH = shp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  shp_pkg::token_t push_token,
  output logic            full,
  output logic            tok_valid,
  output shp_pkg::token_t tok,
  input  logic            pop
);
  import shp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign tok_valid = (count_r != '0);
  assign tok       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

@@ src/shp_back.sv @@
module shp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  shp_pkg::token_t tok,
  output logic            pop,
  output logic            out_valid,
  output logic            out_kind,
  output logic [7:0]      out_value,
  output logic [7:0]      out_frame_count,
  output logic            out_last,
  input  logic            out_stall
);
  import shp_pkg::*;

  phase_t      phase_r, phase_nxt, cur_phase, num_phase, num_nxt;
  logic [1:0]  pm_r, pm_nxt, cur_pm;
  logic [7:0]  acc_r, acc_nxt, cur_acc;
  logic        neg_r, neg_nxt, cur_neg;
  logic [7:0]  width_r, width_nxt, cur_width;
  logic [15:0] bytes_r, bytes_nxt, cur_bytes, bytes_dec;
  logic [3:0]  hi_r, hi_nxt, cur_hi;
  logic        pend_r, pend_nxt, cur_pend;

  logic        take, go, prefix_hit, num_path, num_lead, num_first, sep;
  logic        hdr_empty, data_now, data_last, emit;
  logic [7:0]  sep_val;
  logic [15:0] total;
  logic        res_kind, res_last;
  logic [7:0]  res_value, res_fc;
  logic        out_valid_r;

  assign take = !out_valid_r || !out_stall;
  assign pop  = tok_valid && take;
  assign go   = pop;

  // a start flag clears the parser before its character is looked at
  assign cur_phase = tok.start ? PH_PREFIX : phase_r;
  assign cur_pm    = tok.start ? 2'd0  : pm_r;
  assign cur_acc   = tok.start ? 8'd0  : acc_r;
  assign cur_neg   = tok.start ? 1'b0  : neg_r;
  assign cur_width = tok.start ? 8'd0  : width_r;
  assign cur_bytes = tok.start ? 16'd0 : bytes_r;
  assign cur_hi    = tok.start ? 4'd0  : hi_r;
  assign cur_pend  = tok.start ? 1'b0  : pend_r;

  assign prefix_hit = tok.lead_hit[cur_pm];

  always_comb begin
    case (cur_phase)
      PH_PREFIX: num_path = !prefix_hit;
      PH_TRIM:   num_path = !tok.ws && !tok.comma;
      PH_N1LEAD, PH_N1DIG, PH_N2LEAD, PH_N2DIG: num_path = 1'b1;
      default:   num_path = 1'b0;
    endcase
  end

  assign num_phase = (cur_phase == PH_PREFIX || cur_phase == PH_TRIM) ? PH_N1LEAD : cur_phase;
  assign num_lead  = (num_phase == PH_N1LEAD) || (num_phase == PH_N2LEAD);
  assign num_first = (num_phase == PH_N1LEAD) || (num_phase == PH_N1DIG);
  assign sep       = num_path
                     && !(num_lead && (tok.ws || tok.plus || tok.minus || tok.dec))
                     && !(!num_lead && tok.dec);
  assign sep_val   = cur_neg ? 8'(8'd0 - cur_acc) : cur_acc;
  assign total     = cur_width * sep_val;
  assign hdr_empty = (cur_width == 8'd0) || (sep_val == 8'd0);
  assign data_now  = (cur_phase == PH_DATA) && cur_pend;
  assign bytes_dec = (cur_bytes != 16'd0) ? 16'(cur_bytes - 16'd1) : cur_bytes;
  assign data_last = (bytes_dec == 16'd0);
  assign emit      = (sep && !num_first) || data_now;

  // phase after a number character
  always_comb begin
    if (sep) begin
      num_nxt = num_first ? PH_N2LEAD : (hdr_empty ? PH_DONE : PH_DATA);
    end else if (num_lead && (tok.plus || tok.minus || tok.dec)) begin
      num_nxt = (num_phase == PH_N1LEAD) ? PH_N1DIG : PH_N2DIG;
    end else begin
      num_nxt = num_phase;
    end
  end

  always_comb begin
    unique case (cur_phase)
      PH_PREFIX: begin
        if (prefix_hit) begin
          phase_nxt = (cur_pm == 2'd3) ? PH_TRIM : PH_PREFIX;
        end else begin
          phase_nxt = num_nxt;
        end
      end
      PH_TRIM: begin
        if (tok.ws) begin
          phase_nxt = PH_TRIM;
        end else if (tok.comma) begin
          phase_nxt = PH_N1LEAD;
        end else begin
          phase_nxt = num_nxt;
        end
      end
      PH_N1LEAD, PH_N1DIG, PH_N2LEAD, PH_N2DIG: phase_nxt = num_nxt;
      PH_DATA: phase_nxt = (data_now && data_last) ? PH_DONE : PH_DATA;
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_PREFIX;
    endcase
  end

  always_comb begin
    pm_nxt    = (cur_phase == PH_PREFIX && prefix_hit) ? 2'(cur_pm + 2'd1) : 2'd0;
    acc_nxt   = cur_acc;
    neg_nxt   = cur_neg;
    width_nxt = cur_width;
    bytes_nxt = cur_bytes;
    hi_nxt    = cur_hi;
    pend_nxt  = cur_pend;
    res_kind  = KIND_DATA;
    res_value = {cur_hi, tok.nib};
    res_fc    = 8'd0;
    res_last  = data_last;
    if (num_path) begin
      if (sep) begin
        acc_nxt = 8'd0;
        neg_nxt = 1'b0;
        if (num_first) begin
          width_nxt = sep_val;
        end else begin
          bytes_nxt = total;
          pend_nxt  = 1'b0;
          hi_nxt    = 4'd0;
        end
        res_kind  = KIND_HEADER;
        res_value = cur_width;
        res_fc    = sep_val;
        res_last  = hdr_empty;
      end else if (num_lead) begin
        if (tok.plus || tok.minus) begin
          neg_nxt = tok.minus;
        end else if (tok.dec) begin
          acc_nxt = {4'd0, tok.nib};
        end
      end else begin
        // times ten as two shifts, modulo 256
        acc_nxt = 8'((cur_acc << 3) + (cur_acc << 1) + {4'd0, tok.nib});
      end
    end else if (cur_phase == PH_DATA) begin
      if (!cur_pend) begin
        if (!(tok.space || tok.comma)) begin
          hi_nxt   = tok.nib;
          pend_nxt = 1'b1;
        end
      end else begin
        hi_nxt    = 4'd0;
        pend_nxt  = 1'b0;
        bytes_nxt = bytes_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PREFIX;
      pm_r        <= 2'd0;
      acc_r       <= 8'd0;
      neg_r       <= 1'b0;
      width_r     <= 8'd0;
      bytes_r     <= 16'd0;
      hi_r        <= 4'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        pm_r    <= pm_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        width_r <= width_nxt;
        bytes_r <= bytes_nxt;
        hi_r    <= hi_nxt;
        pend_r  <= pend_nxt;
      end
      if (go && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_kind        <= res_kind;
      out_value       <= res_value;
      out_frame_count <= res_fc;
      out_last        <= res_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/shp_checker.sv @@
`include "sprite_hex_text_parser_defines.svh"

module shp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_kind,
  input logic [7:0] out_value,
  input logic [7:0] out_frame_count,
  input logic       out_last,
  input logic       out_stall
);
  import shp_pkg::*;

  // a result held back by the receiver stays put
  `SHP_ASSERT_ON(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_value))

  // reset empties the result register
  `SHP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid)

  // data bytes carry no frame count
  `SHP_ASSERT_ON(a_data_fc_zero, out_valid && out_kind == KIND_DATA |-> out_frame_count == 8'd0)

  // a header is final exactly when the sprite is empty
  `SHP_ASSERT_ON(a_hdr_last, out_valid && out_kind == KIND_HEADER |-> out_last == (out_value == 8'd0 || out_frame_count == 8'd0))

endmodule

bind sprite_hex_text_parser shp_checker u_shp_checker (.*);

@@ verif/sprite_hex_text_parser_checker.sv @@
module sprite_hex_text_parser_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_ch,
  input  logic       in_start_req,
  input  logic       in_stall,
  input  logic       out_valid,
  input  logic       out_kind,
  input  logic [7:0] out_value,
  input  logic [7:0] out_frame_count,
  input  logic       out_last,
  input  logic       out_stall,
  output int         mismatch_count,
  output int         pending_results,
  output int         headers_checked,
  output int         bytes_checked
);
  import shp_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] frames;
    logic       last;
  } sprite_result_t;

  localparam logic [31:0] LEAD_WORD = "anim";

  // parser state
  phase_t      ph = PH_PREFIX;
  logic [2:0]  lead_cnt = '0;
  logic [7:0]  acc = '0;
  logic        neg = 1'b0;
  logic [7:0]  width_q = '0;
  logic [15:0] remaining = '0;
  logic [3:0]  hi_nib = '0;
  logic        hi_valid = 1'b0;

  sprite_result_t results_due[$];
  sprite_result_t predicted;
  sprite_result_t want;
  int             fail_total = 0;
  int             header_total = 0;
  int             byte_total = 0;
  int             due_q = 0;

  assign mismatch_count  = fail_total;
  assign pending_results = due_q;
  assign headers_checked = header_total;
  assign bytes_checked   = byte_total;

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  function void clear_parser();
    ph        = PH_PREFIX;
    lead_cnt  = '0;
    acc       = '0;
    neg       = 1'b0;
    width_q   = '0;
    remaining = '0;
    hi_nib    = '0;
    hi_valid  = 1'b0;
  endfunction

  // header numbers: lead, digits, then the separator closes the number
  function bit take_number_char(input logic [7:0] c, output sprite_result_t r);
    logic [7:0]  v;
    logic [15:0] prod;
    r = '0;
    if (ph == PH_N1LEAD || ph == PH_N2LEAD) begin
      if (is_space(c)) return 0;
      if (c == "+" || c == "-") begin
        neg = (c == "-");
        ph  = phase_t'(ph + 3'd1);
        return 0;
      end
      if (is_digit(c)) begin
        acc = c - "0";
        ph  = phase_t'(ph + 3'd1);
        return 0;
      end
    end else if (is_digit(c)) begin
      acc = acc * 8'd10 + (c - "0");
      return 0;
    end
    v   = neg ? (8'd0 - acc) : acc;
    acc = '0;
    neg = 1'b0;
    if (ph == PH_N1LEAD || ph == PH_N1DIG) begin
      width_q = v;
      ph      = PH_N2LEAD;
      return 0;
    end
    prod      = width_q * v;
    remaining = prod;
    hi_valid  = 1'b0;
    hi_nib    = '0;
    ph        = (prod != 16'd0) ? PH_DATA : PH_DONE;
    r.kind    = KIND_HEADER;
    r.value   = width_q;
    r.frames  = v;
    r.last    = (prod == 16'd0);
    return 1;
  endfunction

  function bit parse_sprite_char(input logic [7:0] c, input logic start,
                                 output sprite_result_t r);
    r = '0;
    if (start) clear_parser();
    case (ph)
      PH_PREFIX: begin
        if (lead_cnt < 3'd4 && c == LEAD_WORD[31 - 8*lead_cnt -: 8]) begin
          lead_cnt++;
          if (lead_cnt == 3'd4) ph = PH_TRIM;
          return 0;
        end
        // broken prefix: the breaking character opens the width
        lead_cnt = '0;
        ph       = PH_N1LEAD;
        return take_number_char(c, r);
      end
      PH_TRIM: begin
        if (is_space(c)) return 0;
        ph = PH_N1LEAD;
        if (c == ",") return 0;
        return take_number_char(c, r);
      end
      PH_N1LEAD, PH_N1DIG, PH_N2LEAD, PH_N2DIG: begin
        return take_number_char(c, r);
      end
      PH_DATA: begin
        if (!hi_valid) begin
          if (c == " " || c == ",") return 0;
          hi_nib   = hex_nibble(c);
          hi_valid = 1'b1;
          return 0;
        end
        r.kind   = KIND_DATA;
        r.value  = {hi_nib, hex_nibble(c)};
        r.frames = '0;
        hi_valid = 1'b0;
        hi_nib   = '0;
        if (remaining != 16'd0) remaining--;
        r.last = (remaining == 16'd0);
        if (remaining == 16'd0) ph = PH_DONE;
        return 1;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_sprite_char(in_ch, in_start_req, predicted))
          results_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %0h",
                                    out_kind, out_value));
        end else begin
          want = results_due.pop_front();
          check_field("kind", out_kind, want.kind);
          check_field("value", out_value, want.value);
          check_field("frame_count", out_frame_count, want.frames);
          check_field("last", out_last, want.last);
          if (want.kind == KIND_HEADER) header_total++;
          else byte_total++;
        end
      end
    end
    due_q <= results_due.size();
  end

endmodule

@@ verif/sprite_hex_text_parser_tb.sv @@
module sprite_hex_text_parser_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 1000;
  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_ch = '0;
  logic       in_start_req = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_value;
  logic [7:0] out_frame_count;
  logic       out_last;
  logic       out_stall = 1'b0;

  int mismatch_count;
  int pending_results;
  int headers_checked;
  int bytes_checked;

  // knobs for the current idle/stall mix
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  int chars_sent = 0;
  int directed_chars = 0;
  int cycle_count = 0;

  // one sprite text under construction
  logic [7:0] sprite_text[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_hex_text_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ch           (in_ch),
    .in_start_req    (in_start_req),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_frame_count (out_frame_count),
    .out_last        (out_last),
    .out_stall       (out_stall)
  );

  sprite_hex_text_parser_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ch           (in_ch),
    .in_start_req    (in_start_req),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_frame_count (out_frame_count),
    .out_last        (out_last),
    .out_stall       (out_stall),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .headers_checked (headers_checked),
    .bytes_checked   (bytes_checked)
  );

  // receiver back-pressure, random per cycle at the current rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results);
      $display("Mismatches found");
      $finish;
    end
  end

  // one input transaction, with random idle cycles in front of it
  task automatic send_char(input logic [7:0] c, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_start_req <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic with_start);
    for (int i = 0; i < s.len(); i++) send_char(s[i], with_start && i == 0);
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_ws();
    logic [7:0] c;
    c = 8'($urandom_range(14, 9));
    return (c == 8'd14) ? " " : c;
  endfunction

  // anything that closes a number: biased toward the usual separators
  function automatic logic [7:0] pick_non_digit();
    logic [7:0] c;
    case ($urandom_range(3))
      0: return " ";
      1: return ",";
      default: begin
        c = 8'($urandom_range(255));
        while (c >= "0" && c <= "9") c = 8'($urandom_range(255));
        return c;
      end
    endcase
  endfunction

  // mostly hex digits of both cases, sometimes any byte at all
  function automatic logic [7:0] pick_nibble_char();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return HEX_DIGITS[$urandom_range(21)];
  endfunction

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) sprite_text.push_back(s[i]);
  endtask

  // a decimal text that lands on target modulo 256, in one of several spellings
  task automatic add_number(input int target);
    int    n;
    string digits;
    if ($urandom_range(3) == 0) sprite_text.push_back(pick_ws());
    case ($urandom_range(3))
      0: n = target;
      1: n = target + 256 * $urandom_range(1, 3);
      2: begin
        sprite_text.push_back("-");
        n = (256 - target) % 256 + 256 * $urandom_range(0, 1);
      end
      default: begin
        sprite_text.push_back("+");
        n = target;
      end
    endcase
    digits = $sformatf("%0d", n);
    if ($urandom_range(4) == 0) digits = {"0", digits};
    push_string(digits);
  endtask

  // one random sprite text: mostly well formed, some noise, some cut short
  task automatic build_sprite_text();
    int    w;
    int    f;
    int    shape;
    int    keep;
    string lead_word;
    sprite_text.delete();
    lead_word = "anim";
    shape = $urandom_range(99);
    if (shape < 8) begin
      repeat ($urandom_range(1, 12)) sprite_text.push_back(8'($urandom_range(255)));
    end else begin
      // optional lead word, whole or broken off early
      if ($urandom_range(2) == 0) begin
        push_string(lead_word);
        repeat ($urandom_range(2)) sprite_text.push_back(pick_ws());
        if ($urandom_range(1) == 1) sprite_text.push_back(",");
      end else if ($urandom_range(5) == 0) begin
        push_string(lead_word.substr(0, $urandom_range(2)));
      end
      // sizes kept small, with empty sprites carrying extreme header values
      case ($urandom_range(19))
        0: begin
          w = $urandom_range(255);
          f = 0;
        end
        1: begin
          w = 0;
          f = $urandom_range(255);
        end
        2: begin
          w = $urandom_range(16, 32);
          f = 1;
        end
        default: begin
          w = $urandom_range(1, 6);
          f = $urandom_range(1, 3);
        end
      endcase
      add_number(w);
      sprite_text.push_back(pick_non_digit());
      add_number(f);
      sprite_text.push_back(pick_non_digit());
      for (int i = 0; i < w * f; i++) begin
        repeat ($urandom_range(2)) sprite_text.push_back($urandom_range(1) ? " " : ",");
        sprite_text.push_back(pick_nibble_char());
        sprite_text.push_back(pick_nibble_char());
      end
      // trailing junk after the final byte is ignored
      repeat ($urandom_range(2)) sprite_text.push_back(8'($urandom_range(255)));
      // text ending early: the next start abandons it
      if (shape < 20 && sprite_text.size() > 1) begin
        keep = $urandom_range(1, sprite_text.size() - 1);
        while (sprite_text.size() > keep) void'(sprite_text.pop_back());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // no start after reset, broken lead word, non-hex nibbles
    send_text("an1 1 zZ", 1'b0);
    // full lead word then comma, negative zero width, empty sprite, junk after it
    send_text("anim,-0x3;", 1'b1);
    send_char(8'hff, 1'b0);
    // sign with no digit, NUL as separator
    send_text("+;9", 1'b1);
    send_char(8'h00, 1'b0);
    // width wraps to 255 with zero frames
    send_text("-1 0;", 1'b1);
    directed_chars = chars_sent;
    drain(8);

    // random texts under four idle/stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 82;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 82;
        end
        default: begin
          sender_idle_pct    = 25;
          receiver_stall_pct = 25;
        end
      endcase
      while (chars_sent < directed_chars + (p + 1) * RANDOM_CHARS / 4) begin
        build_sprite_text();
        for (int i = 0; i < sprite_text.size(); i++) send_char(sprite_text[i], i == 0);
      end
      drain(8);
    end

    drain(20);
    $display("sent %0d characters over four idle/stall mixes", chars_sent);
    $display("checked %0d header and %0d data byte results", headers_checked,
             bytes_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
